// ===== rtl/max_gradient_fusion_assert.svh =====
`ifndef MAX_GRADIENT_FUSION_ASSERT_SVH
`define MAX_GRADIENT_FUSION_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define MGF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequence holds in the same cycle as the antecedent
`define MGF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence holds in the cycle after the antecedent
`define MGF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mgf_pkg.sv =====
`timescale 1ns / 1ps

package mgf_pkg;

   localparam int PIXEL_W     = 8;
   localparam int PAIR_W      = 2 * PIXEL_W;
   localparam int GRAD_W      = 9;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int ROW_W       = CSR_DATA_W;

   // Output queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic signed [GRAD_W-1:0] grad_type;

   typedef struct packed {
      grad_type grad_x;
      grad_type grad_y;
      logic     end_of_frame;
   } result_type;

   // Control flags carried by an item from acceptance to the gradient stage
   typedef struct packed {
      logic real_item;   // item changes state (not an ignored flush)
      logic older_bank;  // bank holding the row being received
      logic emit_a;      // result for the pixel one column back
      logic emit_b;      // extra result for the last column
      logic top_row;     // centre row is the first image row
      logic drain_row;   // item belongs to the drain row
      logic col_ge2;     // horizontal difference has both neighbours
      logic last_pixel;  // last item of the drain row
   } stage_ctrl_type;

   typedef struct packed {
      stage_ctrl_type        ctrl;
      logic [PIXEL_W-1:0]    bright;
      logic [PIXEL_W-1:0]    dark;
   } stage_type;

   function automatic grad_type pixel_diff(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b);
      return signed'({1'b0, a}) - signed'({1'b0, b});
   endfunction

   // Keep the bright difference unless the dark one is strictly larger in magnitude
   function automatic grad_type pick_grad(grad_type b, grad_type d);
      logic [GRAD_W-1:0] mag_b;
      logic [GRAD_W-1:0] mag_d;
      mag_b = b[GRAD_W-1] ? unsigned'(-b) : unsigned'(b);
      mag_d = d[GRAD_W-1] ? unsigned'(-d) : unsigned'(d);
      return (mag_b >= mag_d) ? b : d;
   endfunction

endpackage

// ===== rtl/mgf_line_bank.sv =====
`timescale 1ns / 1ps

module mgf_line_bank #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [DATA_W-1:0] write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [DATA_W-1:0] read_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] read_data_ff;

   // One write and one registered read per cycle; a read sees the old word
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/mgf_select.sv =====
`timescale 1ns / 1ps

module mgf_select import mgf_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  stage_type         stage,
   input  logic [PAIR_W-1:0] bank0_data,
   input  logic [PAIR_W-1:0] bank1_data,
   output logic              push_a,
   output logic              push_b,
   output result_type        result_a,
   output result_type        result_b
);

   logic [PIXEL_W-1:0] older_bright;
   logic [PIXEL_W-1:0] older_dark;
   logic [PIXEL_W-1:0] newer_bright;
   logic [PIXEL_W-1:0] newer_dark;
   logic               no_vertical;

   // Previous item: current pixel, older-row pixel, and two newer-row taps
   logic [PIXEL_W-1:0] tap_bright_cur_ff;
   logic [PIXEL_W-1:0] tap_dark_cur_ff;
   logic [PIXEL_W-1:0] tap_bright_old_ff;
   logic [PIXEL_W-1:0] tap_dark_old_ff;
   logic [PIXEL_W-1:0] tap_newer_bright_1_ff;
   logic [PIXEL_W-1:0] tap_newer_bright_2_ff;
   logic [PIXEL_W-1:0] tap_newer_dark_1_ff;
   logic [PIXEL_W-1:0] tap_newer_dark_2_ff;

   // Route the two banks to their current roles
   always_comb begin
      if (stage.ctrl.older_bank) begin
         older_bright = bank1_data[PAIR_W-1:PIXEL_W];
         older_dark   = bank1_data[PIXEL_W-1:0];
         newer_bright = bank0_data[PAIR_W-1:PIXEL_W];
         newer_dark   = bank0_data[PIXEL_W-1:0];
      end else begin
         older_bright = bank0_data[PAIR_W-1:PIXEL_W];
         older_dark   = bank0_data[PIXEL_W-1:0];
         newer_bright = bank1_data[PAIR_W-1:PIXEL_W];
         newer_dark   = bank1_data[PIXEL_W-1:0];
      end
   end

   assign no_vertical = stage.ctrl.top_row || stage.ctrl.drain_row;

   // Result for the pixel one row up and one column back, then the last-column extra
   always_comb begin
      result_a.grad_x = stage.ctrl.col_ge2 ?
         pick_grad(pixel_diff(newer_bright, tap_newer_bright_2_ff),
                   pixel_diff(newer_dark, tap_newer_dark_2_ff)) : '0;
      result_a.grad_y = no_vertical ? '0 :
         pick_grad(pixel_diff(tap_bright_cur_ff, tap_bright_old_ff),
                   pixel_diff(tap_dark_cur_ff, tap_dark_old_ff));
      result_a.end_of_frame = 1'b0;

      result_b.grad_x = '0;
      result_b.grad_y = no_vertical ? '0 :
         pick_grad(pixel_diff(stage.bright, older_bright),
                   pixel_diff(stage.dark, older_dark));
      result_b.end_of_frame = stage.ctrl.last_pixel;
   end

   assign push_a = advance && stage.ctrl.emit_a;
   assign push_b = advance && stage.ctrl.emit_b;

   // Taps move only with items that change state
   always_ff @(posedge clock) begin
      if (advance && stage.ctrl.real_item) begin
         tap_bright_cur_ff     <= stage.bright;
         tap_dark_cur_ff       <= stage.dark;
         tap_bright_old_ff     <= older_bright;
         tap_dark_old_ff       <= older_dark;
         tap_newer_bright_1_ff <= newer_bright;
         tap_newer_bright_2_ff <= tap_newer_bright_1_ff;
         tap_newer_dark_1_ff   <= newer_dark;
         tap_newer_dark_2_ff   <= tap_newer_dark_1_ff;
      end
   end

endmodule

// ===== rtl/mgf_out_queue.sv =====
`timescale 1ns / 1ps

module mgf_out_queue import mgf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_a,
   input  logic       push_b,
   input  result_type result_a,
   input  result_type result_b,
   output logic       room,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_result
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic [1:0]             n_push;
   logic                   pop;

   assign n_push    = {1'b0, push_a} + {1'b0, push_b};
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign out_result = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(n_push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Up to two items written in order per cycle
   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= result_a;
      end
      if (push_b) begin
         entry_ff[push_a ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff] <= result_b;
      end
   end

endmodule

// ===== rtl/max_gradient_fusion.sv =====
// Max-gradient selection for two-exposure fusion. Pixel pairs arrive in raster order, one
// item per clock when not stalled; the block forms horizontal and vertical central
// differences for both exposures (zero on border columns and rows) and keeps, per axis,
// the bright difference unless the dark one is larger in magnitude. Results lag one row
// and one pixel: the item at row r, column c gives the result for (r-1, c-1), the last
// column of a row gives two results and the first column none, and a row of drain items
// after the frame gives the last row, marking its final pixel with end_of_frame. The block
// sustains one item per cycle while the output queue has room; that figure is set by the
// line store, two single-write single-read banks holding pixel pairs. An item is registered,
// then queued. Writing either frame register restarts the frame counters.
`timescale 1ns / 1ps
`include "max_gradient_fusion_assert.svh"

module max_gradient_fusion import mgf_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [PIXEL_W-1:0]            req_bright_pixel,
   input  logic [PIXEL_W-1:0]            req_dark_pixel,
   input  logic                          req_flush,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [GRAD_W-1:0]      rsp_grad_x,
   output logic signed [GRAD_W-1:0]      rsp_grad_y,
   output logic                          rsp_end_of_frame,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data
);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int RESET_COLS = (int'(FRAME_WIDTH_RESET) > MAX_WIDTH) ?
                               MAX_WIDTH : int'(FRAME_WIDTH_RESET);
   localparam logic [COL_W-1:0] LAST_COL_RESET = COL_W'(RESET_COLS - 1);

   // Frame geometry and position
   logic [COL_W-1:0] last_col_ff;
   logic [COL_W-1:0] last_col_in;
   logic [ROW_W-1:0] height_ff;
   logic [ROW_W-1:0] height_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             bank_sel_ff;
   logic             bank_sel_in;
   logic             restart;

   // Input stage
   logic             s1_valid_ff;
   logic             s1_valid_in;
   stage_type        s1_ff;
   stage_ctrl_type   ctrl_in;

   logic             accept;
   logic             advance;
   logic             room;
   logic             in_frame;
   logic             is_last;
   logic             line_write;

   logic [PAIR_W-1:0] bank0_data;
   logic [PAIR_W-1:0] bank1_data;
   logic              push_a;
   logic              push_b;
   result_type        result_a;
   result_type        result_b;
   result_type        out_result;

   // Handshake
   assign advance   = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   // Register writes
   always_comb begin
      last_col_in = last_col_ff;
      height_in   = height_ff;
      restart     = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               restart = 1'b1;
               if (csr_write_data == '0) begin
                  last_col_in = '0;
               end else if (32'(csr_write_data) > 32'(MAX_WIDTH)) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_W'(csr_write_data - CSR_DATA_W'(1));
               end
            end
            CSR_FRAME_HEIGHT: begin
               restart   = 1'b1;
               height_in = (csr_write_data == '0) ? ROW_W'(1) : csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Classify the arriving item from the frame position
   assign in_frame   = (row_ff < height_ff);
   assign is_last    = (col_ff == last_col_ff);
   assign line_write = accept && in_frame && !req_flush;

   always_comb begin
      ctrl_in.real_item  = !(in_frame && req_flush);
      ctrl_in.older_bank = bank_sel_ff;
      ctrl_in.emit_a     = ctrl_in.real_item && (col_ff != '0) && (row_ff != '0);
      ctrl_in.emit_b     = ctrl_in.real_item && is_last && (row_ff != '0);
      ctrl_in.top_row    = (row_ff == ROW_W'(1));
      ctrl_in.drain_row  = !in_frame;
      ctrl_in.col_ge2    = (col_ff >= COL_W'(2));
      ctrl_in.last_pixel = !in_frame && is_last;
   end

   // Frame position: line banks swap at each image row end, drain row wraps to zero
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      bank_sel_in = bank_sel_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && ctrl_in.real_item) begin
         if (is_last) begin
            col_in = '0;
            if (in_frame) begin
               row_in      = row_ff + ROW_W'(1);
               bank_sel_in = !bank_sel_ff;
            end else begin
               row_in = '0;
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RESET;
         height_ff   <= FRAME_HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         bank_sel_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         last_col_ff <= last_col_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         bank_sel_ff <= bank_sel_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.ctrl   <= ctrl_in;
         s1_ff.bright <= req_bright_pixel;
         s1_ff.dark   <= req_dark_pixel;
      end
   end

   // Line store: the older bank takes the row being received
   mgf_line_bank #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PAIR_W)
   ) u_bank0 (
      .clock        (clock),
      .write_enable (line_write && !bank_sel_ff),
      .write_addr   (col_ff),
      .write_data   ({req_bright_pixel, req_dark_pixel}),
      .read_enable  (accept),
      .read_addr    (col_ff),
      .read_data    (bank0_data)
   );

   mgf_line_bank #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PAIR_W)
   ) u_bank1 (
      .clock        (clock),
      .write_enable (line_write && bank_sel_ff),
      .write_addr   (col_ff),
      .write_data   ({req_bright_pixel, req_dark_pixel}),
      .read_enable  (accept),
      .read_addr    (col_ff),
      .read_data    (bank1_data)
   );

   mgf_select u_select (
      .clock      (clock),
      .advance    (advance),
      .stage      (s1_ff),
      .bank0_data (bank0_data),
      .bank1_data (bank1_data),
      .push_a     (push_a),
      .push_b     (push_b),
      .result_a   (result_a),
      .result_b   (result_b)
   );

   mgf_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_a     (push_a),
      .push_b     (push_b),
      .result_a   (result_a),
      .result_b   (result_b),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_grad_x       = out_result.grad_x;
   assign rsp_grad_y       = out_result.grad_y;
   assign rsp_end_of_frame = out_result.end_of_frame;

   // Checks
   `MGF_ASSERT_ALWAYS(a_col_within_row, col_ff <= last_col_ff, "column past row end")
   `MGF_ASSERT_ALWAYS(a_row_within_frame, row_ff <= height_ff, "row past drain row")
   `MGF_ASSERT_SAME(a_eof_is_border, rsp_valid && rsp_end_of_frame,
      rsp_grad_x == '0 && rsp_grad_y == '0, "end of frame result not on a border")
   `MGF_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_ff), "held item lost or changed")

endmodule

// ===== tb/sv/gradient_select_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the selected gradients
// of every accepted item and compares each result item with the oldest one due.
module gradient_select_checker import mgf_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_bright_pixel,
   input  logic [PIXEL_W-1:0]     req_dark_pixel,
   input  logic                   req_flush,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  grad_type               rsp_grad_x,
   input  grad_type               rsp_grad_y,
   input  logic                   rsp_end_of_frame,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     pending_results,
   output int                     mismatch_count
);

   localparam int PRINT_CAP = 50;

   // Frame geometry as last written
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;

   // Two line banks per exposure; older_bank receives the current row
   logic [PIXEL_W-1:0] bright_rows [2][MAX_WIDTH];
   logic [PIXEL_W-1:0] dark_rows [2][MAX_WIDTH];
   logic               older_bank;

   int unsigned row_pos;
   int unsigned col_pos;

   // Previous pixel and the value above it, for the vertical difference
   int prev_bright;
   int prev_dark;
   int prev_bright_above;
   int prev_dark_above;

   result_type expected_grads[$];

   function automatic int unsigned active_width();
      if (width_reg == '0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned active_height();
      return (height_reg == '0) ? 1 : 32'(height_reg);
   endfunction

   // Bright wins ties on magnitude
   function automatic int stronger_grad(int bright_diff, int dark_diff);
      int mag_b;
      int mag_d;
      mag_b = (bright_diff < 0) ? -bright_diff : bright_diff;
      mag_d = (dark_diff < 0) ? -dark_diff : dark_diff;
      return (mag_b >= mag_d) ? bright_diff : dark_diff;
   endfunction

   // Horizontal difference for column cc-1 of the row held in the newer bank
   function automatic int horizontal_grad(int unsigned cc);
      logic newer;
      if (cc < 2) return 0;
      newer = ~older_bank;
      return stronger_grad(int'(bright_rows[newer][cc]) - int'(bright_rows[newer][cc-2]),
                           int'(dark_rows[newer][cc]) - int'(dark_rows[newer][cc-2]));
   endfunction

   function automatic void queue_result(int gx, int gy, logic eof);
      result_type r;
      r.grad_x       = gx[GRAD_W-1:0];
      r.grad_y       = gy[GRAD_W-1:0];
      r.end_of_frame = eof;
      expected_grads.push_back(r);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: gradient mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Works out the result items caused by one accepted item
   task automatic predict_gradients(input logic [PIXEL_W-1:0] bp, input logic [PIXEL_W-1:0] dp,
                                    input logic fl);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int          ob;
      int          od;
      int          gy;
      logic        top_row;
      w = active_width();
      h = active_height();
      c = col_pos;
      if (c >= w) c = w - 1;
      if (row_pos < h) begin
         // flush inside the pixel rows is ignored outright
         if (fl) return;
         ob = int'(bright_rows[older_bank][c]);
         od = int'(dark_rows[older_bank][c]);
         if (row_pos >= 1) begin
            top_row = (row_pos == 1);
            if (c >= 1) begin
               gy = top_row ? 0 : stronger_grad(prev_bright - prev_bright_above,
                                                prev_dark - prev_dark_above);
               queue_result(horizontal_grad(c), gy, 1'b0);
            end
            if (c == w - 1) begin
               gy = top_row ? 0 : stronger_grad(int'(bp) - ob, int'(dp) - od);
               queue_result(0, gy, 1'b0);
            end
         end
         bright_rows[older_bank][c] = bp;
         dark_rows[older_bank][c]   = dp;
         prev_bright       = int'(bp);
         prev_dark         = int'(dp);
         prev_bright_above = ob;
         prev_dark_above   = od;
         c++;
         if (c >= w) begin
            c = 0;
            row_pos++;
            older_bank = ~older_bank;
         end
      end else begin
         // drain row: last image row comes out, no vertical difference
         if (c >= 1) queue_result(horizontal_grad(c), 0, 1'b0);
         if (c == w - 1) queue_result(0, 0, 1'b1);
         c++;
         if (c >= w) begin
            c = 0;
            row_pos = 0;
         end
      end
      col_pos = c;
   endtask

   task automatic check_result();
      result_type want;
      if (expected_grads.size() == 0) begin
         report_mismatch($sformatf("unexpected item gx=%0d gy=%0d eof=%0b",
                                   rsp_grad_x, rsp_grad_y, rsp_end_of_frame));
         return;
      end
      want = expected_grads.pop_front();
      if (rsp_grad_x !== want.grad_x)
         report_mismatch($sformatf("grad_x %0d, want %0d", rsp_grad_x, want.grad_x));
      if (rsp_grad_y !== want.grad_y)
         report_mismatch($sformatf("grad_y %0d, want %0d", rsp_grad_y, want.grad_y));
      if (rsp_end_of_frame !== want.end_of_frame)
         report_mismatch($sformatf("end_of_frame %0b, want %0b",
                                   rsp_end_of_frame, want.end_of_frame));
   endtask

   // Results are checked before the same edge's input, which cannot be due yet
   always @(posedge clock) begin
      if (reset) begin
         width_reg         = FRAME_WIDTH_RESET;
         height_reg        = FRAME_HEIGHT_RESET;
         older_bank        = 1'b0;
         row_pos           = 0;
         col_pos           = 0;
         prev_bright       = 0;
         prev_dark         = 0;
         prev_bright_above = 0;
         prev_dark_above   = 0;
         mismatch_count    = 0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            bright_rows[0][i] = '0;
            bright_rows[1][i] = '0;
            dark_rows[0][i]   = '0;
            dark_rows[1][i]   = '0;
         end
         expected_grads.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_write_enable) begin
            // a write to a frame register restarts the frame
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_reg = csr_write_data;
               row_pos   = 0;
               col_pos   = 0;
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_reg = csr_write_data;
               row_pos    = 0;
               col_pos    = 0;
            end
         end
         if (req_valid && !req_stall)
            predict_gradients(req_bright_pixel, req_dark_pixel, req_flush);
      end
      pending_results <= expected_grads.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import mgf_pkg::*;

   localparam int LINE_LENGTH     = 1024;
   localparam int RANDOM_ITEMS    = 200;
   localparam int QUIET_TAIL      = 80;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 200;

   // Indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_bright_pixel;
   logic [PIXEL_W-1:0]     req_dark_pixel;
   logic                   req_flush;
   logic                   rsp_valid;
   logic                   rsp_stall;
   grad_type               rsp_grad_x;
   grad_type               rsp_grad_y;
   logic                   rsp_end_of_frame;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int pending_results;
   int mismatch_count;
   int quiet_cycles;
   int item_total;

   bit sender_idle_on;
   bit receiver_idle_on;
   bit hold_off_request;

   max_gradient_fusion #(
      .MAX_WIDTH (LINE_LENGTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bright_pixel (req_bright_pixel),
      .req_dark_pixel   (req_dark_pixel),
      .req_flush        (req_flush),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_grad_x       (rsp_grad_x),
      .rsp_grad_y       (rsp_grad_y),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gradient_select_checker #(
      .MAX_WIDTH (LINE_LENGTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bright_pixel (req_bright_pixel),
      .req_dark_pixel   (req_dark_pixel),
      .req_flush        (req_flush),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_grad_x       (rsp_grad_x),
      .rsp_grad_y       (rsp_grad_y),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending_results  (pending_results),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: too long with nothing moving on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Result side: one long hold-off on request, otherwise random stall bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Extremes turn up more often than a flat spread would give
   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one item and returns at the edge where it is taken
   task automatic send_item(input logic [PIXEL_W-1:0] bright, input logic [PIXEL_W-1:0] dark,
                            input logic flush);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_bright_pixel <= bright;
      req_dark_pixel   <= dark;
      req_flush        <= flush;
      do @(posedge clock); while (req_stall);
      item_total++;
   endtask

   // Pixel rows then the drain row; stops early at (stop_row, stop_col)
   task automatic send_frame(input int frame_w, input int frame_h,
                             input int stop_row, input int stop_col);
      for (int r = 0; r <= frame_h; r++) begin
         for (int c = 0; c < frame_w; c++) begin
            if (r == stop_row && c == stop_col) return;
            if (r < frame_h) begin
               // stray flush inside the frame, to be ignored
               if ($urandom_range(0, 24) == 0)
                  send_item(PIXEL_W'($urandom_range(0, 255)),
                            PIXEL_W'($urandom_range(0, 255)), 1'b1);
               send_item(random_pixel(), random_pixel(), 1'b0);
            end else if ($urandom_range(0, 3) == 0)
               send_item(PIXEL_W'($urandom_range(0, 255)),
                         PIXEL_W'($urandom_range(0, 255)), 1'b0);
            else
               send_item(PIXEL_W'($urandom_range(0, 255)),
                         PIXEL_W'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // Drop valid, let every due item come out, then give the pipeline time to empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int frame_w, input int frame_h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FRAME_WIDTH;
      csr_write_data   <= frame_w[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index        <= CSR_FRAME_HEIGHT;
      csr_write_data   <= frame_h[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int          start_items;
      int          done_items;
      int          w;
      int          h;
      int          ew;
      int          eh;
      bit          quiet;
      logic [1:0]  idle_mode;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_bright_pixel = '0;
      req_dark_pixel   = '0;
      req_flush        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      hold_off_request = 1'b0;
      item_total       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry: one row at the default width, then the start of the next
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      send_frame(640, 480, 1, 2);
      wait_idle();

      // Directed 3x3 frame: full-scale differences, ties both ways, dark winning
      configure(3, 3);
      send_item(8'd0,   8'd255, 1'b0);
      send_item(8'd0,   8'd0,   1'b0);
      send_item(8'd255, 8'd0,   1'b0);
      // a write to a spare index must not restart the frame
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SPARE_HIGH;
      csr_write_data   <= '1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      send_item(8'd255, 8'd0,   1'b0);
      send_item(8'hAA,  8'h55,  1'b1);
      send_item(8'd128, 8'd128, 1'b0);
      send_item(8'd0,   8'd255, 1'b0);
      send_item(8'd255, 8'd0,   1'b0);
      send_item(8'd10,  8'd5,   1'b0);
      send_item(8'd100, 8'd255, 1'b0);
      // drain row, one item with its flush bit clear
      send_item(8'hFF,  8'hFF,  1'b0);
      send_item(8'h00,  8'h00,  1'b1);
      send_item(8'h00,  8'h00,  1'b1);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SPARE_LOW;
      csr_write_data   <= '0;
      @(posedge clock);
      csr_write_enable <= 1'b0;

      // Largest geometry: width over the line length, zero height; the drain row is cut short
      wait_idle();
      configure(2047, 0);
      send_frame(LINE_LENGTH, 1, 1, 2);
      wait_idle();
      // zero width with a short frame
      configure(0, 4);
      send_frame(1, 4, 5, 0);
      wait_idle();

      // Long hold-off on the result side while items keep coming
      configure(8, 4);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      hold_off_request = 1'b1;
      send_frame(8, 4, 5, 0);
      wait_idle();

      // Random geometries and content; the tail runs without idling
      start_items = item_total;
      done_items  = 0;
      while (done_items < RANDOM_ITEMS) begin
         quiet = (done_items > RANDOM_ITEMS - QUIET_TAIL);
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(17, 32);
            default: w = $urandom_range(3, 16);
         endcase
         case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 2);
            1:       h = $urandom_range(9, 12);
            default: h = $urandom_range(3, 8);
         endcase
         ew = (w == 0) ? 1 : w;
         eh = (h == 0) ? 1 : h;
         wait_idle();
         configure(w, h);
         repeat ($urandom_range(1, 2)) begin
            idle_mode        = 2'($urandom_range(0, 3));
            sender_idle_on   = !quiet && idle_mode[0];
            receiver_idle_on = !quiet && idle_mode[1];
            send_frame(ew, eh, eh + 1, 0);
         end
         // now and then a frame cut short, restarted by the next write
         if (!quiet && $urandom_range(0, 5) == 0)
            send_frame(ew, eh, $urandom_range(0, eh), $urandom_range(0, ew - 1));
         done_items = item_total - start_items;
      end
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      wait_idle();

      @(negedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
